### design/gbks_pkg.sv
// shared widths, table entry type and sequencer states for group_by_key_sum
package gbks_pkg;

   localparam int KEY_W = 24;
   localparam int AMT_W = 40;
   localparam int SUM_W = 48;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [SUM_W-1:0] sum;
   } entry_type;

   localparam int ENTRY_W = KEY_W + SUM_W;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SCAN   = 7'b0000010,
      S_ADD    = 7'b0000100,
      S_APPEND = 7'b0001000,
      S_LOAD   = 7'b0010000,
      S_SHOW   = 7'b0100000,
      S_WAIT   = 7'b1000000
   } state_type;

   localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

### design/group_by_key_sum.sv
// group_by_key_sum top level: per-key saturating sums with batch readout
//
// After its transfer each record holds req_ready low until it is done: the key
// table sits in one ram with a single read port, and the sequencer streams
// one stored key per cycle past a single comparator, then does the saturating
// add, the append or, with the table full, the drop. A record marked
// end_of_batch is followed by the readout: each entry is read, loaded and
// presented, then held while the sink holds rsp_ready low; entries come out newest
// first, the final one with last_of_run set, and the table and the drop flag
// are then empty again. req_ready is high only while no record or readout is
// in progress. There is no clearing pass after reset: only entries below the
// fill count are read.
module group_by_key_sum #(
   parameter int MAX_KEYS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gbks_pkg::KEY_W-1:0]    req_currency_code,
   input  logic signed [gbks_pkg::AMT_W-1:0] req_amount,
   input  logic                          req_end_of_batch,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gbks_pkg::KEY_W-1:0]    rsp_key_out,
   output logic signed [gbks_pkg::SUM_W-1:0] rsp_total,
   output logic                          rsp_last_of_run,
   output logic                          rsp_records_dropped
);

   import gbks_pkg::*;

   localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int CW = $clog2(MAX_KEYS + 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_KEYS);
   localparam logic [CW-1:0] COUNT_ONE = CW'(1);

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             drop_ff, drop_in;
   logic [CW-1:0]    issue_idx_ff, issue_idx_in;
   logic [IW-1:0]    cmp_idx_ff, cmp_idx_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [IW-1:0]    hit_idx_ff, hit_idx_in;
   logic [IW-1:0]    emit_idx_ff, emit_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [KEY_W-1:0] key_ff, key_in;
   logic [AMT_W-1:0] amt_ff, amt_in;
   logic             last_ff, last_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [SUM_W-1:0] rsp_total_ff, rsp_total_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   entry_type        wr_entry;
   logic             rd_en;
   logic [IW-1:0]    rd_addr;
   logic [ENTRY_W-1:0] rd_raw;
   entry_type        rd_entry;

   logic             hit;
   logic             full;
   logic [SUM_W:0]   sum_wide;
   logic [SUM_W-1:0] sum_sat;
   logic [CW-1:0]    count_dec;

   gbks_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_KEYS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry  = entry_type'(rd_raw);
   assign hit       = rd_pend_ff && (rd_entry.key == key_ff);
   assign full      = (count_ff == COUNT_MAX);
   assign count_dec = count_ff - COUNT_ONE;

   // 49-bit sum, clamp when the top two bits disagree
   assign sum_wide = {acc_ff[SUM_W-1], acc_ff}
                   + {{(SUM_W + 1 - AMT_W){amt_ff[AMT_W-1]}}, amt_ff};
   always_comb begin
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      issue_idx_in = issue_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      rd_pend_in   = rd_pend_ff;
      hit_idx_in   = hit_idx_ff;
      emit_idx_in  = emit_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      key_in       = key_ff;
      amt_in       = amt_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = hit_idx_ff;
      wr_entry     = '{key: key_ff, sum: sum_sat};
      rd_en        = 1'b0;
      rd_addr      = issue_idx_ff[IW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in       = req_currency_code;
               amt_in       = req_amount;
               last_in      = req_end_of_batch;
               issue_idx_in = '0;
               rd_pend_in   = 1'b0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            // one key issued and one key compared per cycle
            if (hit) begin
               hit_idx_in = cmp_idx_ff;
               acc_in     = rd_entry.sum;
               rd_pend_in = 1'b0;
               state_in   = S_ADD;
            end else if (issue_idx_ff < count_ff) begin
               rd_en        = 1'b1;
               rd_pend_in   = 1'b1;
               cmp_idx_in   = issue_idx_ff[IW-1:0];
               issue_idx_in = issue_idx_ff + COUNT_ONE;
            end else if (rd_pend_ff) begin
               rd_pend_in = 1'b0;
            end else begin
               state_in = S_APPEND;
            end
         end
         S_ADD: begin
            wr_en       = 1'b1;
            emit_idx_in = count_dec[IW-1:0];
            state_in    = last_ff ? S_LOAD : S_IDLE;
         end
         S_APPEND: begin
            if (full) begin
               drop_in     = 1'b1;
               emit_idx_in = count_dec[IW-1:0];
            end else begin
               wr_en       = 1'b1;
               wr_addr     = count_ff[IW-1:0];
               wr_entry    = '{key: key_ff,
                               sum: {{(SUM_W - AMT_W){amt_ff[AMT_W-1]}}, amt_ff}};
               count_in    = count_ff + COUNT_ONE;
               emit_idx_in = count_ff[IW-1:0];
            end
            state_in = last_ff ? S_LOAD : S_IDLE;
         end
         S_LOAD: begin
            rd_en    = 1'b1;
            rd_addr  = emit_idx_ff;
            state_in = S_SHOW;
         end
         S_SHOW: begin
            rsp_key_in   = rd_entry.key;
            rsp_total_in = rd_entry.sum;
            rsp_last_in  = (emit_idx_ff == '0);
            rsp_valid_in = 1'b1;
            state_in     = S_WAIT;
         end
         S_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (emit_idx_ff == '0) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff - IW'(1);
                  state_in    = S_LOAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         issue_idx_ff <= '0;
         cmp_idx_ff   <= '0;
         rd_pend_ff   <= 1'b0;
         hit_idx_ff   <= '0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         issue_idx_ff <= issue_idx_in;
         cmp_idx_ff   <= cmp_idx_in;
         rd_pend_ff   <= rd_pend_in;
         hit_idx_ff   <= hit_idx_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      amt_ff       <= amt_in;
      last_ff      <= last_in;
      acc_ff       <= acc_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_key_out         = rsp_key_ff;
   assign rsp_total           = rsp_total_ff;
   assign rsp_last_of_run     = rsp_last_ff;
   assign rsp_records_dropped = drop_ff;

   // a result is only presented from the wait state
   a_rsp_in_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_WAIT))
      else $error("result shown outside wait state");

   // no new record while a readout is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready during readout");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("entry count beyond table size");

   // the final transfer of a readout empties the table and clears the flag
   a_clear_after_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_of_run) |=> (count_ff == '0 && !drop_ff))
      else $error("table not emptied after readout");

   a_drop_only_full: assert property (@(posedge clock) disable iff (reset)
      $rose(drop_ff) |-> (count_ff == COUNT_MAX))
      else $error("record dropped with room in table");

endmodule

### design/gbks_ram.sv
// generic single write port, single read port ram with registered read data
module gbks_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/tb.sv
// self-checking testbench for group_by_key_sum: directed, overflow and random batches
`timescale 1ns / 1ps

module tb;
   import gbks_pkg::*;

   localparam int TABLE_DEPTH = 32;

   typedef struct {
      logic [KEY_W-1:0] key;
      logic [SUM_W-1:0] total;
      logic             last;
      logic             dropped;
   } tally_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [KEY_W-1:0]        req_currency_code;
   logic signed [AMT_W-1:0] req_amount;
   logic                    req_end_of_batch;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [KEY_W-1:0]        rsp_key_out;
   logic signed [SUM_W-1:0] rsp_total;
   logic                    rsp_last_of_run;
   logic                    rsp_records_dropped;

   // predictor state
   logic [KEY_W-1:0] key_tab [TABLE_DEPTH];
   logic [SUM_W-1:0] sum_tab [TABLE_DEPTH];
   int               fill;
   bit               dropping;
   tally_type        totals_due [$];

   logic [KEY_W-1:0] key_pool [$];
   bit               steady;
   int               hold_left;
   int               errors;
   int               records_sent;
   int               batches_closed;
   int               totals_seen;
   int               dropped_runs;

   group_by_key_sum #(
      .MAX_KEYS(TABLE_DEPTH)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_currency_code  (req_currency_code),
      .req_amount         (req_amount),
      .req_end_of_batch   (req_end_of_batch),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_key_out        (rsp_key_out),
      .rsp_total          (rsp_total),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_records_dropped(rsp_records_dropped)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // mostly short, a few long
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [AMT_W-1:0] pick_amount();
      logic [63:0] r;
      logic [AMT_W-1:0] a;
      int sel;
      sel = $urandom_range(0, 9);
      r = {$urandom(), $urandom()};
      case (sel)
         0: a = {1'b0, {(AMT_W-1){1'b1}}};
         1: a = {1'b1, {(AMT_W-1){1'b0}}};
         2, 3: begin
            a = {{(AMT_W-12){1'b0}}, r[11:0]};
            if (r[40]) a = -a;
         end
         default: a = r[AMT_W-1:0];
      endcase
      return a;
   endfunction

   function automatic void fill_pool(input int n);
      logic [31:0] r;
      bit fresh;
      key_pool.delete();
      while (key_pool.size() < n) begin
         r = $urandom();
         fresh = 1'b1;
         foreach (key_pool[j]) if (key_pool[j] == r[KEY_W-1:0]) fresh = 1'b0;
         if (fresh) key_pool.push_back(r[KEY_W-1:0]);
      end
   endfunction

   // per-key saturating sum, append or drop, readout newest first on end of batch
   function automatic void accumulate_record(input logic [KEY_W-1:0] key,
                                             input logic [AMT_W-1:0] amt,
                                             input logic eob);
      logic [SUM_W:0] wide;
      tally_type t;
      bit hit;
      int i;
      hit = 1'b0;
      for (i = 0; i < fill; i++) begin
         if (!hit && key_tab[i] == key) begin
            hit = 1'b1;
            wide = {sum_tab[i][SUM_W-1], sum_tab[i]} + {{(SUM_W-AMT_W+1){amt[AMT_W-1]}}, amt};
            if (wide[SUM_W] != wide[SUM_W-1])
               sum_tab[i] = wide[SUM_W] ? SUM_MIN : SUM_MAX;
            else
               sum_tab[i] = wide[SUM_W-1:0];
         end
      end
      if (!hit) begin
         if (fill < TABLE_DEPTH) begin
            key_tab[fill] = key;
            sum_tab[fill] = {{(SUM_W-AMT_W){amt[AMT_W-1]}}, amt};
            fill++;
         end else begin
            dropping = 1'b1;
         end
      end
      if (eob) begin
         for (i = fill - 1; i >= 0; i--) begin
            t.key     = key_tab[i];
            t.total   = sum_tab[i];
            t.last    = (i == 0);
            t.dropped = dropping;
            totals_due.push_back(t);
         end
         if (dropping) dropped_runs++;
         batches_closed++;
         fill     = 0;
         dropping = 1'b0;
      end
   endfunction

   task automatic send_record(input logic [KEY_W-1:0] key, input logic [AMT_W-1:0] amt,
                              input logic eob);
      int gap;
      gap = steady ? 0 : gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_currency_code <= key;
      req_amount        <= amt;
      req_end_of_batch  <= eob;
      do @(posedge clock); while (req_ready !== 1'b1);
      accumulate_record(key, amt, eob);
      records_sent++;
   endtask

   // sink: random stalls, or a long hold-off when asked
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!steady && $urandom_range(0, 7) == 0) stall_left = gap_length();
         end
      end
   end

   // compare every result transfer with the oldest expected total
   initial begin
      tally_type t;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            totals_seen++;
            if (totals_due.size() == 0) begin
               $error("unexpected result: key_out %h total %h", rsp_key_out, rsp_total);
               errors++;
            end else begin
               t = totals_due.pop_front();
               if (rsp_key_out !== t.key) begin
                  $error("key_out: expected %h, got %h", t.key, rsp_key_out);
                  errors++;
               end
               if (rsp_total !== t.total) begin
                  $error("total: expected %h, got %h", t.total, rsp_total);
                  errors++;
               end
               if (rsp_last_of_run !== t.last) begin
                  $error("last_of_run: expected %b, got %b", t.last, rsp_last_of_run);
                  errors++;
               end
               if (rsp_records_dropped !== t.dropped) begin
                  $error("records_dropped: expected %b, got %b", t.dropped,
                         rsp_records_dropped);
                  errors++;
               end
            end
         end
      end
   end

   task automatic test_basic_keys();
      send_record(24'h000000, 40'h00_0000_0000, 1'b1);
      send_record(24'hFFFFFF, 40'h7F_FFFF_FFFF, 1'b0);
      send_record(24'h414243, 40'h80_0000_0000, 1'b0);
      send_record(24'hFFFFFF, 40'hFF_FFFF_FFFF, 1'b0);
      send_record(24'h555555, 40'h55_5555_5555, 1'b0);
      send_record(24'hAAAAAA, 40'hAA_AAAA_AAAA, 1'b0);
      send_record(24'h414243, 40'h00_0000_0001, 1'b0);
      send_record(24'h000000, 40'h00_0000_0000, 1'b0);
      send_record(24'h555555, 40'hAA_AAAA_AAAB, 1'b1);
      // end of batch on a new key
      send_record(24'h123456, 40'h00_0000_0064, 1'b0);
      send_record(24'h654321, 40'hFF_FFFF_FF9C, 1'b1);
   endtask

   // drive one key to each rail, then step back off it
   task automatic test_saturation();
      int n;
      for (n = 0; n < 258; n++) send_record(24'h555344, 40'h7F_FFFF_FFFF, 1'b0);
      send_record(24'h555344, 40'hFF_FFFF_FFFF, 1'b1);
      for (n = 0; n < 258; n++) send_record(24'h455552, 40'h80_0000_0000, n == 0);
      send_record(24'h455552, 40'h00_0000_0001, 1'b1);
   endtask

   task automatic test_table_full();
      int n;
      fill_pool(40);
      for (n = 0; n < TABLE_DEPTH; n++) send_record(key_pool[n], pick_amount(), 1'b0);
      send_record(key_pool[32], pick_amount(), 1'b0);
      send_record(key_pool[5], pick_amount(), 1'b0);
      send_record(key_pool[33], pick_amount(), 1'b0);
      send_record(key_pool[0], pick_amount(), 1'b0);
      send_record(key_pool[34], pick_amount(), 1'b1);
      // exactly full, nothing dropped
      fill_pool(TABLE_DEPTH);
      for (n = 0; n < TABLE_DEPTH; n++)
         send_record(key_pool[n], pick_amount(), n == TABLE_DEPTH - 1);
   endtask

   // long sink hold-off while records keep coming: readout stalls the input
   task automatic test_backpressure();
      int n;
      fill_pool(TABLE_DEPTH);
      for (n = 0; n < TABLE_DEPTH - 1; n++) send_record(key_pool[n], pick_amount(), 1'b0);
      // hold-off starts just before the end of batch so it covers the readout
      hold_left = 400;
      send_record(key_pool[TABLE_DEPTH - 1], pick_amount(), 1'b1);
      for (n = 0; n < 6; n++) send_record(key_pool[n], pick_amount(), n == 5);
   endtask

   task automatic test_random_batches();
      int sent;
      int len;
      int pool_size;
      int n;
      logic [31:0] r;
      logic [KEY_W-1:0] key;
      sent = 0;
      while (sent < 100) begin
         steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) != 0) begin
            len       = $urandom_range(1, 12);
            pool_size = $urandom_range(1, 8);
         end else begin
            len       = $urandom_range(20, 70);
            pool_size = $urandom_range(16, 45);
         end
         fill_pool(pool_size);
         for (n = 0; n < len; n++) begin
            r = $urandom();
            key = ($urandom_range(0, 9) == 0) ? r[KEY_W-1:0]
                                              : key_pool[$urandom_range(0, pool_size - 1)];
            send_record(key, pick_amount(), n == len - 1);
         end
         sent += len;
      end
      steady = 1'b0;
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_currency_code = '0;
      req_amount        = '0;
      req_end_of_batch  = 1'b0;
      fill              = 0;
      dropping          = 1'b0;
      steady            = 1'b0;
      hold_left         = 0;
      errors            = 0;
      records_sent      = 0;
      batches_closed    = 0;
      totals_seen       = 0;
      dropped_runs      = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_keys();
      test_saturation();
      test_table_full();
      test_backpressure();
      test_random_batches();

      req_valid <= 1'b0;
      while (totals_due.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);

      $display("%0d records in %0d batches, %0d totals checked", records_sent,
               batches_closed, totals_seen);
      $display("%0d readouts carried the drop flag", dropped_runs);
      if (errors == 0 && totals_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
